// ===== design/spmb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmb_pkg
// Types and codes shared by the stereo period mix buffer files.
// ----------------------------------------------------------------------------
package spmb_pkg;

   localparam int unsigned PERIOD_W      = 11;
   localparam int unsigned INDEX_W       = 10;
   localparam int unsigned SAMPLE_W      = 16;
   localparam int unsigned FRAME_W       = 2 * SAMPLE_W;
   localparam int unsigned PERIOD_RESET  = 1024;

   typedef enum logic [2:0] {
      REQ_READ  = 3'd0,
      REQ_WRITE = 3'd1,
      REQ_PUSH  = 3'd2,
      REQ_MIX   = 3'd3,
      REQ_CLEAR = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MIX
   } state_type;

   typedef struct packed {
      logic [2:0]                 req_type;
      logic [INDEX_W-1:0]         frame_index;
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
   } req_item_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       index_error;
   } rsp_item_type;

endpackage
`default_nettype wire

// ===== design/stereo_period_mix_buffer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_period_mix_buffer_core
// Stereo frame store of one audio period with read, write, push, mix and
// clear requests on a single-port memory.
// ----------------------------------------------------------------------------
// Every item gives its result in the cycle after it is accepted.
// Write, push and unknown or failed requests leave the block idle; read and mix
// also pass through ST_READ or ST_MIX, set by the registered read of the store.
// Clear occupies the store port after its item while it zeroes all MAX_FRAMES frames.
// Reset runs the same clearing pass: busy stays high until the pass ends.
// The receiver cannot stall; each result strobes for one cycle.
module stereo_period_mix_buffer_core #(
   parameter int unsigned MAX_FRAMES = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire spmb_pkg::req_item_type           req_data,
   output logic                                  rsp_strobe,
   output spmb_pkg::rsp_item_type                rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [spmb_pkg::PERIOD_W-1:0]    csr_data
);
   import spmb_pkg::*;

   localparam int unsigned AW = $clog2(MAX_FRAMES);
   // Wide enough for the raw period and for MAX_FRAMES itself.
   localparam int unsigned CW = ((AW + 1) > PERIOD_W) ? (AW + 1) : PERIOD_W;

   state_type       state_ff, state_in;
   logic [CW-1:0]   period_ff, period_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [AW-1:0]   clr_ff, clr_in;
   req_item_type    req_ff;
   logic            strobe_ff, err_ff, read_ff;
   logic            err_in, read_in;

   logic            accept;
   logic            in_range;
   logic [CW-1:0]   head_inc;
   logic [CW-1:0]   csr_ext;
   logic            mem_en, mem_we;
   logic [AW-1:0]   mem_addr;
   logic [FRAME_W-1:0] mem_wdata, mem_rdata;
   logic [SAMPLE_W-1:0] mix_left, mix_right;

   assign accept    = start && !busy;
   assign busy      = reset || (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign in_range = CW'(req_data.frame_index) < period_ff;
   assign head_inc = CW'(head_ff) + CW'(1);

   // Period is clamped to 1..MAX_FRAMES when written.
   assign csr_ext = CW'(csr_data);
   always_comb begin
      period_in = period_ff;
      if (csr_valid) begin
         if (csr_ext == '0) begin
            period_in = CW'(1);
         end else if (csr_ext > CW'(MAX_FRAMES)) begin
            period_in = CW'(MAX_FRAMES);
         end else begin
            period_in = csr_ext;
         end
      end
   end

   assign mix_left  = mem_rdata[SAMPLE_W-1:0] + req_ff.left_sample;
   assign mix_right = mem_rdata[FRAME_W-1:SAMPLE_W] + req_ff.right_sample;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      clr_in    = clr_ff;
      err_in    = 1'b0;
      read_in   = 1'b0;
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = AW'(req_data.frame_index);
      mem_wdata = {req_data.right_sample, req_data.left_sample};
      unique case (state_ff)
         ST_CLEAR: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_FRAMES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_kind_type'(req_data.req_type))
                  REQ_READ: begin
                     err_in  = !in_range;
                     read_in = in_range;
                     if (in_range) begin
                        mem_en   = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  REQ_WRITE: begin
                     err_in = !in_range;
                     if (in_range) begin
                        mem_en = 1'b1;
                        mem_we = 1'b1;
                     end
                  end
                  REQ_PUSH: begin
                     mem_en   = 1'b1;
                     mem_we   = 1'b1;
                     mem_addr = head_ff;
                     head_in  = (head_inc >= period_ff) ? '0 : AW'(head_inc);
                  end
                  REQ_MIX: begin
                     err_in = !in_range;
                     if (in_range) begin
                        mem_en   = 1'b1;
                        state_in = ST_MIX;
                     end
                  end
                  REQ_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_MIX: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = AW'(req_ff.frame_index);
            mem_wdata = {mix_right, mix_left};
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         head_ff   <= '0;
         period_ff <= (PERIOD_RESET > MAX_FRAMES) ? CW'(MAX_FRAMES) : CW'(PERIOD_RESET);
         strobe_ff <= 1'b0;
         err_ff    <= 1'b0;
         read_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         head_ff   <= head_in;
         period_ff <= period_in;
         strobe_ff <= accept;
         err_ff    <= err_in;
         read_ff   <= read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   spmb_ram #(
      .DEPTH (MAX_FRAMES),
      .WIDTH (FRAME_W)
   ) u_ram (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_strobe           = strobe_ff;
   assign rsp_data.left_out    = read_ff ? mem_rdata[SAMPLE_W-1:0] : '0;
   assign rsp_data.right_out   = read_ff ? mem_rdata[FRAME_W-1:SAMPLE_W] : '0;
   assign rsp_data.index_error = err_ff;

endmodule
`default_nettype wire

// ===== design/spmb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmb_ram
// Single-port frame store with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module spmb_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule
`default_nettype wire

// ===== design/spmb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmb_checker
// Port-level checks of the stereo period mix buffer core.
// ----------------------------------------------------------------------------
module spmb_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    start,
   input wire logic                    busy,
   input wire spmb_pkg::req_item_type  req_data,
   input wire logic                    rsp_strobe,
   input wire spmb_pkg::rsp_item_type  rsp_data
);
   import spmb_pkg::*;

   // Every accepted item is answered in the following cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("no result after an accepted item");

   // A result never appears without an item accepted the cycle before.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy))
      else $error("result without an accepted item");

   // An index error carries zero samples.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.index_error) |->
         (rsp_data.left_out == '0 && rsp_data.right_out == '0))
      else $error("index error with nonzero samples");

   // A clear holds the block busy while the store is swept.
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.req_type == REQ_CLEAR) |=> busy)
      else $error("not busy after clear");

endmodule

bind stereo_period_mix_buffer_core spmb_checker u_spmb_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
`default_nettype wire

// ===== dv/stereo_period_mix_buffer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_period_mix_buffer_core_tb
// Drives read, write, push, mix, clear and unused requests into the stereo
// frame store under several period settings, mirrors the store and write head
// in a local model, and checks every result strobe in order against it or a directed expected value.
// ----------------------------------------------------------------------------
module stereo_period_mix_buffer_core_tb;
   import spmb_pkg::*;

   localparam int unsigned MAX_FRAMES      = 1024;
   localparam int unsigned HALF_PERIOD     = 5;
   localparam int unsigned ITEMS_PER_PHASE = 115;
   localparam int unsigned TIMEOUT_CYCLES  = 2_000_000;
   localparam int unsigned SETTLE_CYCLES   = 16;

   // Request codes the block does not define.
   localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
   localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
   localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;

   typedef struct {
      bit                is_cfg;
      logic [PERIOD_W-1:0] cfg_value;
      req_item_type      item;
      bit                typed;
      rsp_item_type      rsp;
   } plan_row_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   req_item_type        req_data  = '0;
   logic                rsp_strobe;
   rsp_item_type        rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [PERIOD_W-1:0] csr_data  = '0;

   // Local copy of the block state.
   logic [FRAME_W-1:0]  frame_mirror [MAX_FRAMES];
   logic [INDEX_W-1:0]  head_mirror;
   logic [PERIOD_W-1:0] period_mirror;

   rsp_item_type        frame_results_due [$];
   plan_row_type        directed_plan [$];
   logic [PERIOD_W-1:0] phase_periods [$];

   int unsigned fail_count    = 0;
   int unsigned item_count    = 0;
   int unsigned clear_count   = 0;
   int unsigned range_errors  = 0;
   int unsigned setting_count = 0;
   int unsigned burst_left    = 0;

   stereo_period_mix_buffer_core #(
      .MAX_FRAMES(MAX_FRAMES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   function automatic int unsigned live_period();
      if (period_mirror == '0) return 1;
      if (period_mirror > MAX_FRAMES) return MAX_FRAMES;
      return period_mirror;
   endfunction

   // Applies one request to the mirrored store and returns its result.
   function automatic rsp_item_type predict_frame_access(req_item_type it);
      rsp_item_type        r;
      int unsigned         per;
      int unsigned         nxt;
      bit                  in_range;
      logic [SAMPLE_W-1:0] lsum;
      logic [SAMPLE_W-1:0] rsum;
      r        = '0;
      per      = live_period();
      in_range = it.frame_index < per;
      case (it.req_type)
         REQ_READ: begin
            if (in_range) begin
               r.left_out  = frame_mirror[it.frame_index][SAMPLE_W-1:0];
               r.right_out = frame_mirror[it.frame_index][FRAME_W-1:SAMPLE_W];
            end else begin
               r.index_error = 1'b1;
            end
         end
         REQ_WRITE: begin
            if (in_range) frame_mirror[it.frame_index] = {it.right_sample, it.left_sample};
            else r.index_error = 1'b1;
         end
         REQ_PUSH: begin
            // The head may sit past a shrunken period; it still writes there.
            frame_mirror[head_mirror] = {it.right_sample, it.left_sample};
            nxt = head_mirror + 1;
            head_mirror = (nxt >= per) ? '0 : INDEX_W'(nxt);
         end
         REQ_MIX: begin
            if (in_range) begin
               lsum = frame_mirror[it.frame_index][SAMPLE_W-1:0] + it.left_sample;
               rsum = frame_mirror[it.frame_index][FRAME_W-1:SAMPLE_W] + it.right_sample;
               frame_mirror[it.frame_index] = {rsum, lsum};
            end else begin
               r.index_error = 1'b1;
            end
         end
         REQ_CLEAR: begin
            foreach (frame_mirror[i]) frame_mirror[i] = '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void cfg_row(logic [PERIOD_W-1:0] value);
      plan_row_type row;
      row           = '{default: '0};
      row.is_cfg    = 1'b1;
      row.cfg_value = value;
      directed_plan.push_back(row);
   endfunction

   function automatic void req_row(logic [2:0] kind, logic [INDEX_W-1:0] idx,
                                   logic [SAMPLE_W-1:0] ls, logic [SAMPLE_W-1:0] rs);
      plan_row_type row;
      row      = '{default: '0};
      row.item = '{req_type: kind, frame_index: idx, left_sample: ls, right_sample: rs};
      directed_plan.push_back(row);
   endfunction

   function automatic void chk_row(logic [2:0] kind, logic [INDEX_W-1:0] idx,
                                   logic [SAMPLE_W-1:0] ls, logic [SAMPLE_W-1:0] rs,
                                   logic [SAMPLE_W-1:0] el, logic [SAMPLE_W-1:0] er,
                                   logic ee);
      plan_row_type row;
      row       = '{default: '0};
      row.item  = '{req_type: kind, frame_index: idx, left_sample: ls, right_sample: rs};
      row.typed = 1'b1;
      row.rsp   = '{left_out: el, right_out: er, index_error: ee};
      directed_plan.push_back(row);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 11))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic req_item_type random_frame_req();
      req_item_type it;
      int unsigned  pick;
      int unsigned  per;
      int unsigned  hot;
      per  = live_period();
      hot  = (per < 8) ? per : 8;
      pick = $urandom_range(0, 99);
      if (pick < 32)      it.req_type = REQ_READ;
      else if (pick < 52) it.req_type = REQ_WRITE;
      else if (pick < 70) it.req_type = REQ_PUSH;
      else if (pick < 94) it.req_type = REQ_MIX;
      else if (pick < 96) it.req_type = REQ_CLEAR;
      else if (pick < 97) it.req_type = REQ_UNUSED_LO;
      else if (pick < 98) it.req_type = REQ_UNUSED_MID;
      else                it.req_type = REQ_UNUSED_HI;
      // Many indexes land in up to eight hot frames so reads and mixes see earlier writes.
      case ($urandom_range(0, 9))
         0, 1:       it.frame_index = INDEX_W'($urandom);
         2, 3, 4, 5: it.frame_index = INDEX_W'($urandom_range(0, hot - 1));
         default:    it.frame_index = INDEX_W'($urandom_range(0, per - 1));
      endcase
      it.left_sample  = pick_sample();
      it.right_sample = pick_sample();
      return it;
   endfunction

   // Bursts of back-to-back items separated by idle gaps, some of them empty.
   task automatic sender_gap();
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic offer_item(req_item_type it, bit typed, rsp_item_type typed_rsp);
      rsp_item_type predicted;
      req_data <= it;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = predict_frame_access(it);
      frame_results_due.push_back(typed ? typed_rsp : predicted);
      item_count++;
      if (it.req_type == REQ_CLEAR) clear_count++;
      if (predicted.index_error) range_errors++;
   endtask

   task automatic write_period(logic [PERIOD_W-1:0] value);
      start <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      // A clear keeps the store port busy well after its result.
      while (busy) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      period_mirror  = value;
      setting_count++;
   endtask

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_strobe) begin
         if (frame_results_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected result left=%h right=%h err=%b", $realtime,
                        rsp_data.left_out, rsp_data.right_out, rsp_data.index_error);
         end else begin
            want = frame_results_due.pop_front();
            if (rsp_data.left_out !== want.left_out || rsp_data.right_out !== want.right_out
                || rsp_data.index_error !== want.index_error) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: mismatch: expected left=%h right=%h err=%b, got left=%h right=%h err=%b",
                           $realtime, want.left_out, want.right_out, want.index_error,
                           rsp_data.left_out, rsp_data.right_out, rsp_data.index_error);
            end
         end
      end
   end

   initial begin
      #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
      $display("Timeout with %0d results outstanding.", frame_results_due.size());
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      foreach (frame_mirror[i]) frame_mirror[i] = '0;
      head_mirror   = '0;
      period_mirror = PERIOD_W'(PERIOD_RESET);

      // Store extremes, mix wrap, push at the head, unused code and clear.
      chk_row(REQ_READ,       10'd0,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      chk_row(REQ_READ,       10'd1023, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      chk_row(REQ_WRITE,      10'd0,    16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b0);
      chk_row(REQ_WRITE,      10'd1023, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
      chk_row(REQ_READ,       10'd0,    16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 1'b0);
      chk_row(REQ_READ,       10'd1023, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 1'b0);
      chk_row(REQ_MIX,        10'd0,    16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      chk_row(REQ_READ,       10'd0,    16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 1'b0);
      chk_row(REQ_PUSH,       10'd1023, 16'h1234, 16'hABCD, 16'h0000, 16'h0000, 1'b0);
      chk_row(REQ_READ,       10'd0,    16'h0000, 16'h0000, 16'h1234, 16'hABCD, 1'b0);
      chk_row(REQ_PUSH,       10'd0,    16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      chk_row(REQ_READ,       10'd1,    16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
      chk_row(REQ_UNUSED_HI,  10'd1023, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      chk_row(REQ_CLEAR,      10'd0,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      chk_row(REQ_READ,       10'd0,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      // Period shrinks below the head; then zero and oversized periods.
      cfg_row(11'd2);
      req_row(REQ_PUSH,       10'd0,    16'h5555, 16'hAAAA);
      chk_row(REQ_READ,       10'd2,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      chk_row(REQ_WRITE,      10'd1023, 16'h1111, 16'h2222, 16'h0000, 16'h0000, 1'b1);
      chk_row(REQ_MIX,        10'd2,    16'h0101, 16'h0202, 16'h0000, 16'h0000, 1'b1);
      req_row(REQ_PUSH,       10'd0,    16'h0F0F, 16'hF0F0);
      cfg_row(11'd0);
      chk_row(REQ_READ,       10'd1,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      req_row(REQ_READ,       10'd0,    16'h0000, 16'h0000);
      req_row(REQ_PUSH,       10'd0,    16'h7FFF, 16'h7FFF);
      cfg_row(11'd2047);
      req_row(REQ_READ,       10'd2,    16'h0000, 16'h0000);
      req_row(REQ_MIX,        10'd1023, 16'h8000, 16'h8000);
      req_row(REQ_READ,       10'd1023, 16'h0000, 16'h0000);

      phase_periods = '{11'd1024, 11'd1, 11'd2, 11'd0, 11'd2047, 11'd1023,
                        PERIOD_W'($urandom_range(3, 64)),
                        PERIOD_W'($urandom_range(0, 2047)), 11'd16, 11'd1024};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_cfg) begin
            write_period(directed_plan[i].cfg_value);
         end else begin
            sender_gap();
            offer_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].rsp);
         end
      end

      foreach (phase_periods[p]) begin
         write_period(phase_periods[p]);
         repeat (ITEMS_PER_PHASE) begin
            sender_gap();
            offer_item(random_frame_req(), 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d items under %0d period settings, including %0d clears",
               item_count, setting_count, clear_count);
      $display("and %0d out-of-range accesses; %0d failures seen.", range_errors, fail_count);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
